>>> hdl/acfb_pkg.sv
// ----------------------------------------------------------------------------
// acfb_pkg: shared types and constants
// Command codes, state encoding, payload structs and the machine's state
// record used by the actuator command/feedback block.
// ----------------------------------------------------------------------------
package acfb_pkg;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned TimerW = 17;

  // Commanded state codes.
  localparam logic [1:0] CMD_IDLE     = 2'd0;
  localparam logic [1:0] CMD_ACTIVE   = 2'd1;
  localparam logic [1:0] CMD_INACTIVE = 2'd2;

  // Reported state codes.
  localparam logic [2:0] ACT_IDLE       = 3'd0;
  localparam logic [2:0] ACT_ACTIVE     = 3'd1;
  localparam logic [2:0] ACT_INACTIVE   = 3'd2;
  localparam logic [2:0] ACT_PROCESSING = 3'd3;
  localparam logic [2:0] ACT_RESET      = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ERROR_INTERVAL = 2'd0;
  localparam logic [1:0] REG_ON_SETTLE      = 2'd1;
  localparam logic [1:0] REG_OFF_SETTLE     = 2'd2;

  localparam logic [TimeW-1:0] ON_SETTLE_RESET  = 16'd6500;
  localparam logic [TimeW-1:0] OFF_SETTLE_RESET = 16'd1000;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_ACTIVE     = 5'b00010,
    ST_INACTIVE   = 5'b00100,
    ST_PROCESSING = 5'b01000,
    ST_RESET      = 5'b10000
  } acfb_state_e;

  typedef struct packed {
    logic [TimeW-1:0] period;
    logic [1:0]       commanded_state;
    logic [TimeW-1:0] sensor_count;
    logic             error_clear;
  } acfb_in_t;

  typedef struct packed {
    logic [2:0] actual_state;
    logic       drive;
    logic       fault;
  } acfb_out_t;

  typedef struct packed {
    logic [TimeW-1:0] error_interval;
    logic [TimeW-1:0] on_settle_time;
    logic [TimeW-1:0] off_settle_time;
  } acfb_cfg_t;

  typedef struct packed {
    acfb_state_e       state;
    logic [TimerW-1:0] on_timer;
    logic [TimerW-1:0] off_timer;
    logic [TimeW-1:0]  mismatch_timer;
    logic              drive;
    logic              error;
  } acfb_ctx_t;

  function automatic logic [2:0] state_code(acfb_state_e st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:       code = ACT_IDLE;
      ST_ACTIVE:     code = ACT_ACTIVE;
      ST_INACTIVE:   code = ACT_INACTIVE;
      ST_PROCESSING: code = ACT_PROCESSING;
      ST_RESET:      code = ACT_RESET;
      default:       code = ACT_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/acfb_next.sv
// ----------------------------------------------------------------------------
// acfb_next: next-state logic for one tick
// Computes the machine's state, timers, drive and error flag after one
// input word, from the current state and the configuration registers.
// ----------------------------------------------------------------------------
module acfb_next (
  input  acfb_pkg::acfb_ctx_t cur_i,
  input  acfb_pkg::acfb_in_t  in_i,
  input  acfb_pkg::acfb_cfg_t cfg_i,
  output acfb_pkg::acfb_ctx_t nxt_o
);
  import acfb_pkg::*;

  logic                sensor;
  logic [TimerW:0]     on_sum;
  logic [TimerW:0]     off_sum;
  logic [TimerW-1:0]   on_sat;
  logic [TimerW-1:0]   off_sat;
  logic [TimeW-1:0]    mm_sum;
  logic                mm_hit;

  assign sensor  = |in_i.sensor_count;
  assign on_sum  = {1'b0, cur_i.on_timer} + {2'b00, in_i.period};
  assign off_sum = {1'b0, cur_i.off_timer} + {2'b00, in_i.period};
  assign on_sat  = on_sum[TimerW] ? '1 : on_sum[TimerW-1:0];
  assign off_sat = off_sum[TimerW] ? '1 : off_sum[TimerW-1:0];
  assign mm_sum  = cur_i.mismatch_timer + in_i.period;
  assign mm_hit  = mm_sum >= cfg_i.error_interval;

  always_comb begin
    nxt_o = cur_i;
    if (in_i.error_clear) begin
      nxt_o.error = 1'b0;
    end
    unique case (cur_i.state)
      ST_IDLE: begin
        if (in_i.commanded_state == CMD_ACTIVE) begin
          nxt_o.state = sensor ? ST_RESET : ST_PROCESSING;
        end else if (in_i.commanded_state == CMD_INACTIVE) begin
          nxt_o.state = sensor ? ST_PROCESSING : ST_INACTIVE;
        end
      end
      ST_ACTIVE: begin
        if (in_i.commanded_state == CMD_INACTIVE) begin
          nxt_o.state = ST_PROCESSING;
        end
      end
      ST_INACTIVE: begin
        if (in_i.commanded_state == CMD_ACTIVE) begin
          nxt_o.state = ST_PROCESSING;
        end
      end
      ST_PROCESSING: begin
        nxt_o.drive = 1'b1;
        if (in_i.commanded_state == CMD_ACTIVE) begin
          nxt_o.off_timer = '0;
          if (sensor) begin
            nxt_o.mismatch_timer = '0;
            if (on_sat >= {1'b0, cfg_i.on_settle_time}) begin
              nxt_o.drive    = 1'b0;
              nxt_o.state    = ST_ACTIVE;
              nxt_o.on_timer = '0;
            end else begin
              nxt_o.on_timer = on_sat;
            end
          end else if (mm_hit) begin
            nxt_o.mismatch_timer = '0;
            nxt_o.error          = 1'b1;
          end else begin
            nxt_o.mismatch_timer = mm_sum;
          end
        end else if (in_i.commanded_state == CMD_INACTIVE) begin
          nxt_o.on_timer = '0;
          if (!sensor) begin
            nxt_o.mismatch_timer = '0;
            if (off_sat >= {1'b0, cfg_i.off_settle_time}) begin
              nxt_o.drive     = 1'b0;
              nxt_o.state     = ST_INACTIVE;
              nxt_o.off_timer = '0;
            end else begin
              nxt_o.off_timer = off_sat;
            end
          end else if (mm_hit) begin
            nxt_o.mismatch_timer = '0;
            nxt_o.error          = 1'b1;
          end else begin
            nxt_o.mismatch_timer = mm_sum;
          end
        end
      end
      ST_RESET: begin
        nxt_o.drive = 1'b1;
        if (!sensor) begin
          if (off_sat >= {1'b0, cfg_i.off_settle_time}) begin
            nxt_o.drive     = 1'b0;
            nxt_o.state     = ST_INACTIVE;
            nxt_o.off_timer = '0;
          end else begin
            nxt_o.off_timer = off_sat;
          end
        end
      end
      default: begin
        nxt_o.state = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/actuator_command_feedback_fsm.sv
// ----------------------------------------------------------------------------
// actuator_command_feedback_fsm: actuator command/feedback state machine
// Tracks a two-position actuator against its position sensor, drives the
// actuator while switching and flags a sensor that disagrees too long.
// ----------------------------------------------------------------------------
// Usage:
// Each input word is one tick: elapsed period, commanded state, sensor
// reading and an error-clear bit. The block returns one output word per
// input word with the state, drive level and sticky error flag after it.
// Configuration words (error interval, on-settle and off-settle times) come
// on a separate valid/ready channel that is always ready; indexes beyond
// the register list are ignored. Write them only while the block is idle.
// Output valid rises in the cycle after input acceptance, and one word per
// cycle is sustained while the receiver keeps up: the state update and the
// output register are loaded in the same cycle. The output register holds
// its word while the receiver stalls; a new input word is still taken in
// the cycle the held word leaves. Reset returns the machine to idle with all
// timers, drive and error cleared, the error interval at 0 and the settle
// times at 6500 and 1000 ms.
module actuator_command_feedback_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acfb_pkg::acfb_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acfb_pkg::acfb_out_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import acfb_pkg::*;

  acfb_cfg_t cfg_q;
  acfb_ctx_t ctx_q;
  acfb_ctx_t ctx_d;
  acfb_out_t out_q;
  logic      out_valid_q;
  logic      in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  acfb_next u_next (
    .cur_i (ctx_q),
    .in_i  (in_i),
    .cfg_i (cfg_q),
    .nxt_o (ctx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.error_interval  <= '0;
      cfg_q.on_settle_time  <= ON_SETTLE_RESET;
      cfg_q.off_settle_time <= OFF_SETTLE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ERROR_INTERVAL: cfg_q.error_interval  <= cfg_data_i;
        REG_ON_SETTLE:      cfg_q.on_settle_time  <= cfg_data_i;
        REG_OFF_SETTLE:     cfg_q.off_settle_time <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state          <= ST_IDLE;
      ctx_q.on_timer       <= '0;
      ctx_q.off_timer      <= '0;
      ctx_q.mismatch_timer <= '0;
      ctx_q.drive          <= 1'b0;
      ctx_q.error          <= 1'b0;
      out_valid_q          <= 1'b0;
    end else if (in_fire) begin
      ctx_q       <= ctx_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.actual_state <= state_code(ctx_d.state);
      out_q.drive        <= ctx_d.drive;
      out_q.fault        <= ctx_d.error;
    end
  end

  // The actuator is energized only while switching or recovering.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.drive |-> (ctx_q.state == ST_PROCESSING || ctx_q.state == ST_RESET))
    else $error("drive energized outside processing or reset");

  // All timers are clear whenever the machine rests in a settled state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.state == ST_IDLE || ctx_q.state == ST_ACTIVE || ctx_q.state == ST_INACTIVE)
    |-> (ctx_q.on_timer == '0 && ctx_q.off_timer == '0 && ctx_q.mismatch_timer == '0))
    else $error("timer left running in a settled state");

  // The error flag can only be raised by a tick taken while switching.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ctx_q.error) |-> ($past(ctx_q.state) == ST_PROCESSING && $past(in_fire)))
    else $error("error flag raised outside processing");

endmodule

>>> tb/actuator_command_feedback_fsm_tb.sv
// ----------------------------------------------------------------------------
// actuator_command_feedback_fsm_tb: self-checking bench for the actuator FSM
// Drives tick words from a directed table and then from random command
// sessions, mirrors the machine in a behavioral predictor and compares
// every output word field by field, under changing settings and stalls.
// ----------------------------------------------------------------------------
module actuator_command_feedback_fsm_tb;
  import acfb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned BATCH_WORDS = 217;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    acfb_in_t   word;
    bit         pinned;
    acfb_out_t  want;
    logic [1:0] reg_index;
    logic [15:0] reg_value;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  acfb_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  acfb_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int unsigned send_idle = 26;
  int unsigned recv_idle = 67;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  bit word_pinned = 1'b0;
  acfb_out_t word_want = '0;
  acfb_out_t expected_q[$];
  plan_row_t plan_q[$];

  logic [15:0] cfg_error_interval;
  logic [15:0] cfg_on_settle;
  logic [15:0] cfg_off_settle;
  logic [2:0]  m_state;
  logic [16:0] m_on_timer;
  logic [16:0] m_off_timer;
  logic [15:0] m_mismatch;
  logic        m_drive;
  logic        m_error;

  actuator_command_feedback_fsm uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [16:0] sat_add17(logic [16:0] a, logic [15:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {2'b00, b};
    return (s > 18'h1FFFF) ? 17'h1FFFF : s[16:0];
  endfunction

  function automatic void bump_mismatch(logic [15:0] period);
    m_mismatch = m_mismatch + period;
    if (m_mismatch >= cfg_error_interval) begin
      m_mismatch = '0;
      m_error = 1'b1;
    end
  endfunction

  function automatic acfb_out_t step_actuator(acfb_in_t t);
    logic sensed;
    logic [1:0] cmd;
    acfb_out_t r;
    sensed = (t.sensor_count != '0);
    cmd = t.commanded_state;
    if (t.error_clear) m_error = 1'b0;
    case (m_state)
      ACT_IDLE: begin
        if (cmd == CMD_ACTIVE) m_state = sensed ? ACT_RESET : ACT_PROCESSING;
        else if (cmd == CMD_INACTIVE) m_state = sensed ? ACT_PROCESSING : ACT_INACTIVE;
      end
      ACT_ACTIVE: if (cmd == CMD_INACTIVE) m_state = ACT_PROCESSING;
      ACT_INACTIVE: if (cmd == CMD_ACTIVE) m_state = ACT_PROCESSING;
      ACT_PROCESSING: begin
        m_drive = 1'b1;
        if (cmd == CMD_ACTIVE) begin
          m_off_timer = '0;
          if (sensed) begin
            m_mismatch = '0;
            m_on_timer = sat_add17(m_on_timer, t.period);
            if (m_on_timer >= {1'b0, cfg_on_settle}) begin
              m_drive = 1'b0;
              m_state = ACT_ACTIVE;
              m_on_timer = '0;
            end
          end else begin
            bump_mismatch(t.period);
          end
        end else if (cmd == CMD_INACTIVE) begin
          m_on_timer = '0;
          if (!sensed) begin
            m_mismatch = '0;
            m_off_timer = sat_add17(m_off_timer, t.period);
            if (m_off_timer >= {1'b0, cfg_off_settle}) begin
              m_drive = 1'b0;
              m_state = ACT_INACTIVE;
              m_off_timer = '0;
            end
          end else begin
            bump_mismatch(t.period);
          end
        end
      end
      ACT_RESET: begin
        m_drive = 1'b1;
        if (!sensed) begin
          m_off_timer = sat_add17(m_off_timer, t.period);
          if (m_off_timer >= {1'b0, cfg_off_settle}) begin
            m_drive = 1'b0;
            m_state = ACT_INACTIVE;
            m_off_timer = '0;
          end
        end
      end
      default: ;
    endcase
    r.actual_state = m_state;
    r.drive = m_drive;
    r.fault = m_error;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    acfb_out_t predicted;
    acfb_out_t exp_word;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output word: state %0d drive %0b error %0b",
                     out_data.actual_state, out_data.drive, out_data.fault);
        end else begin
          exp_word = expected_q.pop_front();
          if ((out_data.actual_state !== exp_word.actual_state) ||
              (out_data.drive !== exp_word.drive) ||
              (out_data.fault !== exp_word.fault)) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: state %0d/%0d drive %0b/%0b error %0b/%0b (exp/got)",
                       exp_word.actual_state, out_data.actual_state,
                       exp_word.drive, out_data.drive,
                       exp_word.fault, out_data.fault);
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = step_actuator(in_data);
        expected_q.push_back(word_pinned ? word_want : predicted);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ERROR_INTERVAL: cfg_error_interval = cfg_data;
          REG_ON_SETTLE:      cfg_on_settle = cfg_data;
          REG_OFF_SETTLE:     cfg_off_settle = cfg_data;
          default: ;
        endcase
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void plan_tick(logic [15:0] period, logic [1:0] cmd, logic [15:0] reading,
                                    logic clr, bit pinned, logic [2:0] st, logic drv,
                                    logic err);
    plan_row_t row;
    row.kind = ROW_TICK;
    row.word.period = period;
    row.word.commanded_state = cmd;
    row.word.sensor_count = reading;
    row.word.error_clear = clr;
    row.pinned = pinned;
    row.want.actual_state = st;
    row.want.drive = drv;
    row.want.fault = err;
    row.reg_index = '0;
    row.reg_value = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_write(logic [1:0] idx, logic [15:0] val);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.word = '0;
    row.pinned = 1'b0;
    row.want = '0;
    row.reg_index = idx;
    row.reg_value = val;
    plan_q.push_back(row);
  endfunction

  task automatic send_tick(acfb_in_t t, bit pinned, acfb_out_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    word_pinned = pinned;
    word_want = want;
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_sessions(int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    int unsigned pick;
    logic [1:0] cmd;
    logic sensed;
    acfb_in_t t;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 42) cmd = CMD_ACTIVE;
      else if (pick < 84) cmd = CMD_INACTIVE;
      else if (pick < 94) cmd = CMD_IDLE;
      else cmd = CMD_UNUSED;
      run_len = $urandom_range(1, 40);
      for (k = 0; k < run_len && sent < count; k++) begin
        t.commanded_state = ($urandom_range(99) < 8) ? 2'($urandom_range(3)) : cmd;
        case ($urandom_range(9))
          0: t.period = 16'($urandom());
          1, 2: t.period = 16'($urandom_range(2000));
          default: t.period = 16'($urandom_range(200));
        endcase
        if (cmd == CMD_ACTIVE) sensed = ($urandom_range(99) < 75);
        else if (cmd == CMD_INACTIVE) sensed = ($urandom_range(99) >= 75);
        else sensed = 1'($urandom_range(1));
        if (!sensed) t.sensor_count = '0;
        else begin
          case ($urandom_range(7))
            0: t.sensor_count = 16'hFFFF;
            1: t.sensor_count = 16'd1;
            default: t.sensor_count = 16'($urandom_range(1, 65535));
          endcase
        end
        t.error_clear = ($urandom_range(99) < 6);
        send_tick(t, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : main
    plan_row_t row;
    int unsigned b;
    cfg_error_interval = '0;
    cfg_on_settle = ON_SETTLE_RESET;
    cfg_off_settle = OFF_SETTLE_RESET;
    m_state = ACT_IDLE;
    m_on_timer = '0;
    m_off_timer = '0;
    m_mismatch = '0;
    m_drive = 1'b0;
    m_error = 1'b0;

    plan_tick(16'h0000, CMD_IDLE,     16'h0000, 1'b0, 1'b1, ACT_IDLE,       1'b0, 1'b0);
    plan_tick(16'hFFFF, CMD_UNUSED,   16'hFFFF, 1'b1, 1'b1, ACT_IDLE,       1'b0, 1'b0);
    plan_tick(16'd7,    CMD_ACTIVE,   16'h0001, 1'b0, 1'b1, ACT_RESET,      1'b0, 1'b0);
    plan_tick(16'd999,  CMD_ACTIVE,   16'h0000, 1'b0, 1'b1, ACT_RESET,      1'b1, 1'b0);
    plan_tick(16'hFFFF, CMD_ACTIVE,   16'hFFFF, 1'b0, 1'b1, ACT_RESET,      1'b1, 1'b0);
    plan_tick(16'd1,    CMD_INACTIVE, 16'h0000, 1'b0, 1'b1, ACT_INACTIVE,   1'b0, 1'b0);
    plan_tick(16'd50,   CMD_INACTIVE, 16'hFFFF, 1'b0, 1'b1, ACT_INACTIVE,   1'b0, 1'b0);
    plan_tick(16'd50,   CMD_UNUSED,   16'h0000, 1'b0, 1'b1, ACT_INACTIVE,   1'b0, 1'b0);
    plan_tick(16'd0,    CMD_ACTIVE,   16'h0000, 1'b0, 1'b1, ACT_PROCESSING, 1'b0, 1'b0);
    plan_tick(16'd5,    CMD_ACTIVE,   16'h0000, 1'b0, 1'b1, ACT_PROCESSING, 1'b1, 1'b1);
    plan_tick(16'd100,  CMD_IDLE,     16'h0001, 1'b0, 1'b1, ACT_PROCESSING, 1'b1, 1'b1);
    plan_tick(16'hFFFF, CMD_UNUSED,   16'h0000, 1'b0, 1'b1, ACT_PROCESSING, 1'b1, 1'b1);
    plan_tick(16'd6499, CMD_ACTIVE,   16'h0001, 1'b1, 1'b1, ACT_PROCESSING, 1'b1, 1'b0);
    plan_tick(16'd1,    CMD_ACTIVE,   16'h8000, 1'b0, 1'b1, ACT_ACTIVE,     1'b0, 1'b0);
    plan_tick(16'd30,   CMD_ACTIVE,   16'h0000, 1'b0, 1'b1, ACT_ACTIVE,     1'b0, 1'b0);
    plan_tick(16'd30,   CMD_IDLE,     16'h0000, 1'b0, 1'b1, ACT_ACTIVE,     1'b0, 1'b0);
    plan_tick(16'd0,    CMD_INACTIVE, 16'h0001, 1'b0, 1'b1, ACT_PROCESSING, 1'b0, 1'b0);
    plan_tick(16'd3,    CMD_INACTIVE, 16'h0001, 1'b0, 1'b1, ACT_PROCESSING, 1'b1, 1'b1);
    plan_tick(16'hFFFF, CMD_INACTIVE, 16'h0000, 1'b1, 1'b1, ACT_INACTIVE,   1'b0, 1'b0);
    plan_write(REG_ERROR_INTERVAL, 16'hFFFF);
    plan_write(REG_ON_SETTLE, 16'h0000);
    plan_write(REG_OFF_SETTLE, 16'h0000);
    plan_write(REG_UNUSED, 16'hFFFF);
    plan_tick(16'h1234, CMD_ACTIVE,   16'h0000, 1'b0, 1'b0, ACT_IDLE,       1'b0, 1'b0);
    plan_tick(16'hFFFF, CMD_ACTIVE,   16'h0000, 1'b0, 1'b0, ACT_IDLE,       1'b0, 1'b0);
    plan_tick(16'd0,    CMD_ACTIVE,   16'h0001, 1'b0, 1'b1, ACT_ACTIVE,     1'b0, 1'b1);
    plan_tick(16'h5A5A, CMD_INACTIVE, 16'h0000, 1'b0, 1'b0, ACT_IDLE,       1'b0, 1'b0);
    plan_tick(16'd0,    CMD_INACTIVE, 16'h0000, 1'b1, 1'b1, ACT_INACTIVE,   1'b0, 1'b0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_WRITE) write_reg(row.reg_index, row.reg_value);
      else send_tick(row.word, row.pinned, row.want);
    end

    for (b = 0; b < 6; b++) begin
      if (b / 2 == 0) begin
        send_idle = 26;
        recv_idle = 67;
      end else if (b / 2 == 1) begin
        send_idle = 67;
        recv_idle = 26;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (b == 1) begin
        write_reg(REG_ERROR_INTERVAL, 16'hFFFF);
        write_reg(REG_ON_SETTLE, 16'hFFFF);
        write_reg(REG_OFF_SETTLE, 16'hFFFF);
      end else if (b == 3) begin
        write_reg(REG_ERROR_INTERVAL, 16'h0000);
        write_reg(REG_ON_SETTLE, 16'h0000);
        write_reg(REG_OFF_SETTLE, 16'h0000);
      end else begin
        write_reg(REG_ERROR_INTERVAL, 16'($urandom_range(1500)));
        write_reg(REG_ON_SETTLE, 16'($urandom_range(3000)));
        write_reg(REG_OFF_SETTLE, 16'($urandom_range(3000)));
      end
      run_sessions(BATCH_WORDS);
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && expected_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
